FILE: design/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared codes and constants of the matrix multiply block.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int CFG_W       = 4;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    FUNC_WRITE_A  = 2'd0,
    FUNC_WRITE_B  = 2'd1,
    FUNC_MULTIPLY = 2'd2
  } func_t;

endpackage

FILE: design/rmm_front.sv
// ----------------------------------------------------------------------------
// rmm_front
// Accepts input transactions, drops unused codes and out-of-store writes,
// and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module rmm_front #(
  parameter int ADDR_W      = 6,
  parameter int DATA_WIDTH  = 16,
  parameter int STORE_DEPTH = 64
) (
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   func,
  input  logic [ADDR_W-1:0]            index,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         queue_full,
  output logic                         push,
  output rmm_pkg::func_t               push_op,
  output logic [ADDR_W-1:0]            push_index,
  output logic signed [DATA_WIDTH-1:0] push_value
);

  logic in_range;
  logic keep;

  assign in_range = (32'(index) < 32'(STORE_DEPTH));

  always_comb begin
    keep    = 1'b0;
    push_op = rmm_pkg::FUNC_MULTIPLY;
    case (func)
      rmm_pkg::FUNC_WRITE_A: begin
        keep    = in_range;
        push_op = rmm_pkg::FUNC_WRITE_A;
      end
      rmm_pkg::FUNC_WRITE_B: begin
        keep    = in_range;
        push_op = rmm_pkg::FUNC_WRITE_B;
      end
      rmm_pkg::FUNC_MULTIPLY: begin
        keep    = 1'b1;
        push_op = rmm_pkg::FUNC_MULTIPLY;
      end
      default: begin
        keep    = 1'b0;
        push_op = rmm_pkg::FUNC_MULTIPLY;
      end
    endcase
  end

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full && keep;
  assign push_index = index;
  assign push_value = value;

endmodule

FILE: design/rmm_queue.sv
// ----------------------------------------------------------------------------
// rmm_queue
// Short command queue between the front and the multiply engine.
// ----------------------------------------------------------------------------
module rmm_queue #(
  parameter int ADDR_W     = 6,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  rmm_pkg::func_t               push_op,
  input  logic [ADDR_W-1:0]            push_index,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  output logic                         full,
  input  logic                         pop,
  output logic                         empty,
  output rmm_pkg::func_t               head_op,
  output logic [ADDR_W-1:0]            head_index,
  output logic signed [DATA_WIDTH-1:0] head_value
);

  localparam int DEPTH = rmm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = rmm_pkg::QUEUE_PTR_W;

  rmm_pkg::func_t              op_mem    [DEPTH];
  logic [ADDR_W-1:0]           index_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] value_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      op_mem[wr_ptr]    <= push_op;
      index_mem[wr_ptr] <= push_index;
      value_mem[wr_ptr] <= push_value;
    end
  end

  assign head_op    = op_mem[rd_ptr];
  assign head_index = index_mem[rd_ptr];
  assign head_value = value_mem[rd_ptr];

endmodule

FILE: design/rmm_back.sv
// ----------------------------------------------------------------------------
// rmm_back
// Element stores, dimension registers and the multiply-accumulate walk that
// emits the product in row-major order through an output register.
// ----------------------------------------------------------------------------
module rmm_back #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16,
  parameter int ADDR_W     = 6,
  parameter int IDX_W      = 3,
  parameter int PROD_W     = 35
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rmm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              empty,
  output logic                              pop,
  input  rmm_pkg::func_t                    head_op,
  input  logic [ADDR_W-1:0]                 head_index,
  input  logic signed [DATA_WIDTH-1:0]      head_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [PROD_W-1:0]          product,
  output logic [IDX_W-1:0]                  row,
  output logic [IDX_W-1:0]                  col,
  output logic                              last
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;

  logic [rmm_pkg::CFG_W-1:0] rows_a;
  logic [rmm_pkg::CFG_W-1:0] inner_dim;
  logic [rmm_pkg::CFG_W-1:0] cols_b;

  logic signed [DATA_WIDTH-1:0] mem_a [STORE_DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_b [STORE_DEPTH];

  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  z;
  logic [IDX_W-1:0]  m_last;
  logic [IDX_W-1:0]  k_last;
  logic [IDX_W-1:0]  n_last;
  logic [ADDR_W-1:0] k_step;
  logic [ADDR_W-1:0] n_step;
  logic [ADDR_W-1:0] a_base;
  logic [ADDR_W-1:0] a_ptr;
  logic [ADDR_W-1:0] b_ptr;

  logic                           rd_valid;
  logic                           mul_valid;
  logic signed [DATA_WIDTH-1:0]   a_q;
  logic signed [DATA_WIDTH-1:0]   b_q;
  logic signed [2*DATA_WIDTH-1:0] prod_q;
  logic signed [PROD_W-1:0]       acc;

  logic issue;
  logic drained;
  logic out_free;
  logic load;
  logic last_elem;
  logic start;

  function automatic int clamp_dim(logic [rmm_pkg::CFG_W-1:0] r);
    int d;
    d = int'(r);
    if (d == 0) begin
      d = 1;
    end else if (d > MAX_DIM) begin
      d = MAX_DIM;
    end
    return d;
  endfunction

  assign cfg_ready = 1'b1;
  assign out_free  = !result_valid || !result_stall;
  assign issue     = (state == ST_RUN);
  assign drained   = !rd_valid && !mul_valid;
  assign last_elem = (i == m_last) && (j == n_last);
  assign load      = (state == ST_DRAIN) && drained && out_free;
  assign pop       = (state == ST_IDLE) && !empty;
  assign start     = pop && (head_op == rmm_pkg::FUNC_MULTIPLY);

  // control and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rows_a       <= rmm_pkg::CFG_W'(1);
      inner_dim    <= rmm_pkg::CFG_W'(1);
      cols_b       <= rmm_pkg::CFG_W'(1);
      rd_valid     <= 1'b0;
      mul_valid    <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rmm_pkg::CFG_ROWS_A:    rows_a    <= cfg_data;
          rmm_pkg::CFG_INNER_DIM: inner_dim <= cfg_data;
          rmm_pkg::CFG_COLS_B:    cols_b    <= cfg_data;
          default: begin
          end
        endcase
      end

      rd_valid  <= issue;
      mul_valid <= rd_valid;

      if (load) begin
        acc <= '0;
      end else if (mul_valid) begin
        acc <= acc + PROD_W'(prod_q);
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        result_valid <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            state  <= ST_RUN;
            i      <= '0;
            j      <= '0;
            z      <= '0;
            a_base <= '0;
            a_ptr  <= '0;
            b_ptr  <= '0;
            m_last <= IDX_W'(clamp_dim(rows_a) - 1);
            k_last <= IDX_W'(clamp_dim(inner_dim) - 1);
            n_last <= IDX_W'(clamp_dim(cols_b) - 1);
            k_step <= ADDR_W'(clamp_dim(inner_dim));
            n_step <= ADDR_W'(clamp_dim(cols_b));
          end
        end
        ST_RUN: begin
          z     <= z + 1'b1;
          a_ptr <= a_ptr + 1'b1;
          b_ptr <= b_ptr + n_step;
          if (z == k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            z <= '0;
            if (last_elem) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RUN;
              if (j == n_last) begin
                j      <= '0;
                i      <= i + 1'b1;
                a_base <= a_base + k_step;
                a_ptr  <= a_base + k_step;
                b_ptr  <= '0;
              end else begin
                j     <= j + 1'b1;
                a_ptr <= a_base;
                b_ptr <= ADDR_W'(j + 1'b1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // element stores and datapath
  always_ff @(posedge clk) begin
    if (pop && (head_op == rmm_pkg::FUNC_WRITE_A)) begin
      mem_a[head_index] <= head_value;
    end
    if (pop && (head_op == rmm_pkg::FUNC_WRITE_B)) begin
      mem_b[head_index] <= head_value;
    end
    if (issue) begin
      a_q <= mem_a[a_ptr];
      b_q <= mem_b[b_ptr];
    end
    if (rd_valid) begin
      prod_q <= a_q * b_q;
    end
    if (load) begin
      product <= acc;
      row     <= i;
      col     <= j;
      last    <= last_elem;
    end
  end

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || mul_valid) |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("multiply pipeline busy outside a walk");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && z == '0 && !rd_valid && !mul_valid) |-> (acc == '0))
    else $error("accumulator not clear at start of element");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && last_elem) |=> (state == ST_IDLE && result_valid && last))
    else $error("final element did not end the walk");

  a_next_elem: assert property (@(posedge clk) disable iff (rst)
    (load && !last_elem) |=> (state == ST_RUN && !last))
    else $error("walk did not continue after a non-final element");

endmodule

FILE: design/real_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// real_matrix_multiply_top
// Matrix multiply of signed fixed-point elements, A (rows_a x inner_dim)
// times B (inner_dim x cols_b), both held row-major in on-chip stores.
// Write transactions (func 0 for A, 1 for B) load one element each and are
// taken one per cycle while the queue has room; they pass through a
// four-entry command queue, so they may keep arriving while a multiply is
// still emitting. A multiply transaction (func 2) emits all rows_a*cols_b
// product elements in row-major order, each with its row, column and a last
// flag on the final one. One multiply-accumulate unit walks the stores
// through a single read port per store, and the walk waits while the output
// stalls. Func 3 and writes beyond the store are accepted and dropped.
// Dimension registers read as 1 when 0 and as MAX_DIM when larger; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Elements read before they were written are undefined.
// ----------------------------------------------------------------------------
module real_matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rmm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rmm_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [1:0]                             func,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] index,
  input  logic signed [DATA_WIDTH-1:0]           value,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [2*DATA_WIDTH+$clog2(MAX_DIM)-1:0] product,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] row,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col,
  output logic                                   last
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PROD_W      = 2 * DATA_WIDTH + $clog2(MAX_DIM);

  logic                         push;
  rmm_pkg::func_t               push_op;
  logic [ADDR_W-1:0]            push_index;
  logic signed [DATA_WIDTH-1:0] push_value;
  logic                         queue_full;
  logic                         queue_empty;
  logic                         pop;
  rmm_pkg::func_t               head_op;
  logic [ADDR_W-1:0]            head_index;
  logic signed [DATA_WIDTH-1:0] head_value;

  rmm_front #(
    .ADDR_W      (ADDR_W),
    .DATA_WIDTH  (DATA_WIDTH),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .index      (index),
    .value      (value),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op),
    .push_index (push_index),
    .push_value (push_value)
  );

  rmm_queue #(
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_index (push_index),
    .push_value (push_value),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .head_op    (head_op),
    .head_index (head_index),
    .head_value (head_value)
  );

  rmm_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W),
    .IDX_W      (IDX_W),
    .PROD_W     (PROD_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .empty        (queue_empty),
    .pop          (pop),
    .head_op      (head_op),
    .head_index   (head_index),
    .head_value   (head_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .product      (product),
    .row          (row),
    .col          (col),
    .last         (last)
  );

endmodule

FILE: tb/sv/real_matrix_multiply_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// real_matrix_multiply_top_test
// Self-checking bench for the matrix multiply block. Element writes, unused
// codes and multiplies are queued and driven with random gaps; accepted writes
// and register writes update an in-bench copy of the stores and dimension
// registers, and every multiply predicts its full row-major set of product
// elements. The output side stalls at random, once for a long stretch so the
// command queue backs up. Dimensions change between phases while idle.
// ----------------------------------------------------------------------------
module real_matrix_multiply_top_test;

  localparam int MAX_DIM = 8;
  localparam int DATA_WIDTH = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 460;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [1:0]         func;
    logic [5:0]         idx;
    logic signed [15:0] val;
  } mat_cmd_t;

  typedef struct {
    logic signed [34:0] product;
    logic [2:0]         row;
    logic [2:0]         col;
    logic               last;
  } prod_elem_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rmm_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [rmm_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic [1:0]                       func = '0;
  logic [5:0]                       index = '0;
  logic signed [15:0]               value = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic signed [34:0]               product;
  logic [2:0]                       row;
  logic [2:0]                       col;
  logic                             last;

  // in-bench copy of the block state
  logic [3:0]         dim_rows = 4'd1;
  logic [3:0]         dim_inner = 4'd1;
  logic [3:0]         dim_cols = 4'd1;
  logic signed [15:0] a_elems [STORE_DEPTH];
  logic signed [15:0] b_elems [STORE_DEPTH];

  // generation side: dimensions and which elements hold data
  int gen_m = 1;
  int gen_k = 1;
  int gen_n = 1;
  bit a_loaded [STORE_DEPTH];
  bit b_loaded [STORE_DEPTH];
  int cmds_queued = 0;

  mat_cmd_t   cmd_pending [$];
  prod_elem_t product_expected [$];

  bit     item_took = 1'b0;
  bit     send_idle_on = 1'b1;
  bit     recv_idle_on = 1'b1;
  bit     hold_armed = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  longint cycle_count = 0;

  int error_count = 0;
  int n_writes = 0;
  int n_multiplies = 0;
  int n_unused = 0;
  int n_results = 0;
  int n_cfg_writes = 0;
  int n_input_stalls = 0;

  real_matrix_multiply_top #(
    .MAX_DIM(MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int effective_dim(logic [3:0] raw);
    if (raw == 4'd0) begin
      return 1;
    end
    if (raw > 4'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  function automatic void predict_command(mat_cmd_t c);
    int m;
    int k;
    int n;
    longint acc;
    prod_elem_t e;
    m = effective_dim(dim_rows);
    k = effective_dim(dim_inner);
    n = effective_dim(dim_cols);
    case (c.func)
      rmm_pkg::FUNC_WRITE_A: begin
        a_elems[c.idx] = c.val;
        n_writes++;
      end
      rmm_pkg::FUNC_WRITE_B: begin
        b_elems[c.idx] = c.val;
        n_writes++;
      end
      rmm_pkg::FUNC_MULTIPLY: begin
        n_multiplies++;
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int z = 0; z < k; z++) begin
              acc += longint'(a_elems[i*k+z]) * longint'(b_elems[z*n+j]);
            end
            e.product = acc[34:0];
            e.row = 3'(i);
            e.col = 3'(j);
            e.last = (i == m - 1) && (j == n - 1);
            product_expected.push_back(e);
          end
        end
      end
      default: begin
        n_unused++;
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_cmd(logic [1:0] f, logic [5:0] ix, logic signed [15:0] v);
    mat_cmd_t c;
    c.func = f;
    c.idx = ix;
    c.val = v;
    cmd_pending.push_back(c);
    if (f == rmm_pkg::FUNC_WRITE_A) begin
      a_loaded[ix] = 1'b1;
    end else if (f == rmm_pkg::FUNC_WRITE_B) begin
      b_loaded[ix] = 1'b1;
    end
    cmds_queued++;
  endfunction

  // loads any element the multiply will read that holds no data yet
  function automatic void push_multiply();
    for (int i = 0; i < gen_m * gen_k; i++) begin
      if (!a_loaded[i]) begin
        push_cmd(rmm_pkg::FUNC_WRITE_A, 6'(i), rand_value());
      end
    end
    for (int i = 0; i < gen_k * gen_n; i++) begin
      if (!b_loaded[i]) begin
        push_cmd(rmm_pkg::FUNC_WRITE_B, 6'(i), rand_value());
      end
    end
    push_cmd(rmm_pkg::FUNC_MULTIPLY, 6'($urandom), 16'($urandom));
  endfunction

  function automatic void push_active_write();
    if ($urandom_range(0, 1) == 0) begin
      push_cmd(rmm_pkg::FUNC_WRITE_A, 6'($urandom_range(0, gen_m * gen_k - 1)),
               rand_value());
    end else begin
      push_cmd(rmm_pkg::FUNC_WRITE_B, 6'($urandom_range(0, gen_k * gen_n - 1)),
               rand_value());
    end
  endfunction

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 9) == 0) begin
      return 4'($urandom_range(0, 15));
    end
    return 4'($urandom_range(1, MAX_DIM));
  endfunction

  task automatic wait_idle();
    while (cmd_pending.size() != 0 || item_valid || product_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [3:0] r, logic [3:0] k, logic [3:0] c);
    logic [rmm_pkg::CFG_INDEX_W-1:0] reg_code [3];
    logic [rmm_pkg::CFG_W-1:0]       reg_val [3];
    reg_code = '{rmm_pkg::CFG_ROWS_A, rmm_pkg::CFG_INNER_DIM, rmm_pkg::CFG_COLS_B};
    reg_val = '{r, k, c};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_code[i];
      cfg_data <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    gen_m = effective_dim(r);
    gen_k = effective_dim(k);
    gen_n = effective_dim(c);
  endtask

  // handshake sampling, prediction and result checking
  always @(posedge clk) begin : monitor
    mat_cmd_t   taken;
    prod_elem_t want;
    item_took = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rmm_pkg::CFG_ROWS_A: dim_rows = cfg_data;
          rmm_pkg::CFG_INNER_DIM: dim_inner = cfg_data;
          rmm_pkg::CFG_COLS_B: dim_cols = cfg_data;
          default: ;
        endcase
        n_cfg_writes++;
      end
      if (item_valid && item_stall) begin
        n_input_stalls++;
      end
      if (item_valid && !item_stall) begin
        item_took = 1'b1;
        taken.func = func;
        taken.idx = index;
        taken.val = value;
        predict_command(taken);
      end
      if (result_valid && !result_stall) begin
        n_results++;
        if (product_expected.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("cycle %0d: unexpected product element row %0d col %0d product %0d",
                     cycle_count, row, col, product);
          end
        end else begin
          want = product_expected.pop_front();
          if (product !== want.product || row !== want.row || col !== want.col ||
              last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("cycle %0d: expected product %0d row %0d col %0d last %0d", cycle_count,
                       want.product, want.row, want.col, want.last);
              $display("cycle %0d:      got product %0d row %0d col %0d last %0d", cycle_count,
                       product, row, col, last);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    mat_cmd_t next_cmd;
    if (!rst && (!item_valid || item_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        item_valid <= 1'b0;
      end else if (cmd_pending.size() != 0) begin
        next_cmd = cmd_pending.pop_front();
        item_valid <= 1'b1;
        func <= next_cmd.func;
        index <= next_cmd.idx;
        value <= next_cmd.val;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, including one long hold
  always @(negedge clk) begin
    if (hold_armed && !hold_done && result_valid) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_stall <= 1'b1;
    end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
      recv_gap = $urandom_range(1, 10) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d product elements outstanding", cycle_count,
               product_expected.size());
      $display("real_matrix_multiply_top regression: fail");
      $finish;
    end
  end

  initial begin
    int  pick;
    bit  quiet;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 1x1x1 after reset: sign extremes, unused code, top store index
    push_cmd(rmm_pkg::FUNC_WRITE_A, 6'd0, 16'h8000);
    push_cmd(rmm_pkg::FUNC_WRITE_B, 6'd0, 16'h8000);
    push_cmd(rmm_pkg::FUNC_MULTIPLY, 6'd63, 16'hFFFF);
    push_cmd(rmm_pkg::FUNC_WRITE_B, 6'd0, 16'h7FFF);
    push_cmd(rmm_pkg::FUNC_MULTIPLY, 6'd0, 16'h0000);
    push_cmd(FUNC_UNUSED, 6'd63, 16'h7FFF);
    push_cmd(FUNC_UNUSED, 6'd0, 16'h8000);
    push_cmd(rmm_pkg::FUNC_WRITE_A, 6'd63, 16'h7FFF);
    push_cmd(rmm_pkg::FUNC_WRITE_B, 6'd63, 16'h8000);
    push_cmd(rmm_pkg::FUNC_WRITE_A, 6'd0, 16'h7FFF);
    push_cmd(rmm_pkg::FUNC_MULTIPLY, 6'd21, 16'h5555);

    // zero dimensions act as one
    write_dims(4'd0, 4'd0, 4'd0);
    push_cmd(rmm_pkg::FUNC_WRITE_A, 6'd0, 16'hFFFF);
    push_cmd(rmm_pkg::FUNC_MULTIPLY, 6'd42, 16'hAAAA);

    // oversize dimensions clamp to the maximum: largest and smallest sums
    write_dims(4'd15, 4'd15, 4'd15);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      push_cmd(rmm_pkg::FUNC_WRITE_A, 6'(i), 16'h8000);
      push_cmd(rmm_pkg::FUNC_WRITE_B, 6'(i), 16'h8000);
    end
    push_multiply();
    for (int i = 0; i < MAX_DIM; i++) begin
      push_cmd(rmm_pkg::FUNC_WRITE_A, 6'(i), 16'h7FFF);
    end
    push_multiply();

    write_dims(4'd8, 4'd1, 4'd8);
    push_multiply();
    write_dims(4'd1, 4'd8, 4'd1);
    push_multiply();

    // long output hold with the sender kept busy
    write_dims(4'd2, 4'd3, 4'd2);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    hold_armed = 1'b1;
    push_multiply();
    repeat (24) push_active_write();
    push_multiply();
    wait_idle();
    hold_armed = 1'b0;

    while (cmds_queued < ITEM_TARGET) begin
      quiet = cmds_queued >= ITEM_TARGET - 40;
      write_dims(pick_dim(), pick_dim(), pick_dim());
      send_idle_on = !quiet && $urandom_range(0, 3) != 0;
      recv_idle_on = !quiet && $urandom_range(0, 3) != 0;
      repeat ($urandom_range(15, 40)) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          push_active_write();
        end else if (pick < 12) begin
          push_cmd(2'($urandom_range(0, 1)), 6'($urandom), rand_value());
        end else if (pick < 14) begin
          push_cmd(FUNC_UNUSED, 6'($urandom), 16'($urandom));
        end else begin
          push_multiply();
        end
      end
      push_multiply();
    end

    wait_idle();
    $display("%0d product elements checked from %0d multiplies, %0d element writes,",
             n_results, n_multiplies, n_writes);
    $display("%0d unused-code transactions, %0d register writes, %0d input stall cycles",
             n_unused, n_cfg_writes, n_input_stalls);
    if (error_count == 0 && product_expected.size() == 0) begin
      $display("real_matrix_multiply_top regression: pass");
    end else begin
      $display("real_matrix_multiply_top regression: fail");
    end
    $finish;
  end

endmodule
